// File: rtl/cte_pkg.sv
package cte_pkg;

    localparam int unsigned YearW  = 12;
    localparam int unsigned DayW   = 6;
    localparam int unsigned MonW   = 4;
    localparam int unsigned TimeW  = 6;
    localparam int unsigned ZoneW  = 20;
    localparam int unsigned EpochW = 37;
    localparam int unsigned DaysW  = 20;
    localparam int unsigned TodW   = 17;
    localparam int unsigned QW     = 6;

    localparam logic [YearW-1:0] EpochYear  = 12'd1970;
    localparam logic [YearW-1:0] Century    = 12'd100;
    localparam logic [YearW-1:0] WinLow     = 12'd1900;
    localparam logic [YearW-1:0] WinHigh    = 12'd2000;
    localparam logic [YearW-1:0] WinSplit   = 12'd70;
    localparam logic [MonW-1:0]  MonFeb     = 4'd1;
    localparam logic [MonW-1:0]  MonDec     = 4'd11;
    // leaps_through(1969)
    localparam logic [YearW-1:0] LeapsBase  = 12'd477;
    // y/100 as (y * 5243) >> 19, exact for all 12-bit y
    localparam logic [12:0]      Recip100   = 13'd5243;
    localparam int unsigned      RecipShift = 19;
    localparam logic [16:0]      SecsDay    = 17'd86400;
    localparam logic [11:0]      SecsHour   = 12'd3600;
    localparam logic [5:0]       SecsMin    = 6'd60;
    localparam logic [8:0]       DaysYear   = 9'd365;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [YearW-1:0]  year;
        logic [MonW-1:0]   mon;
        logic [DayW-1:0]   day;
        logic [TimeW-1:0]  hour;
        logic [TimeW-1:0]  minute;
        logic [TimeW-1:0]  sec;
        logic [ZoneW-1:0]  zone;
    } t_fld;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [DaysW-1:0]  days;
        logic [TodW-1:0]   tod;
        logic [ZoneW-1:0]  zone;
    } t_days;

    function automatic logic [4:0] month_len(input logic [MonW-1:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MonW-1:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/cte_field_check.sv
module cte_field_check
    import cte_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DayW-1:0]  i_day,
    input  logic [MonW-1:0]  i_mon,
    input  logic [YearW-1:0] i_year,
    input  logic [TimeW-1:0] i_hour,
    input  logic [TimeW-1:0] i_minute,
    input  logic [TimeW-1:0] i_sec,
    input  logic [ZoneW-1:0] i_zone,
    output t_fld             o_fld
);

    t_fld             r_fld;
    t_fld             n_fld;
    logic [YearW-1:0] year_win;

    always_comb begin
        // two-digit years land in 1970..2069
        if (i_year < Century) begin
            if (i_year < WinSplit) begin
                year_win = i_year + WinHigh;
            end else begin
                year_win = i_year + WinLow;
            end
        end else begin
            year_win = i_year;
        end
        n_fld.valid  = i_valid;
        n_fld.ok     = (year_win >= EpochYear) && (i_mon <= MonDec)
                       && (i_hour < 6'd24) && (i_minute < 6'd60) && (i_sec < 6'd60);
        n_fld.year   = year_win;
        n_fld.mon    = i_mon;
        n_fld.day    = i_day;
        n_fld.hour   = i_hour;
        n_fld.minute = i_minute;
        n_fld.sec    = i_sec;
        n_fld.zone   = i_zone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld.valid <= 1'b0;
        end else begin
            r_fld.valid <= n_fld.valid;
        end
        r_fld.ok     <= n_fld.ok;
        r_fld.year   <= n_fld.year;
        r_fld.mon    <= n_fld.mon;
        r_fld.day    <= n_fld.day;
        r_fld.hour   <= n_fld.hour;
        r_fld.minute <= n_fld.minute;
        r_fld.sec    <= n_fld.sec;
        r_fld.zone   <= n_fld.zone;
    end

    assign o_fld = r_fld;

endmodule

// File: rtl/cte_day_count.sv
module cte_day_count
    import cte_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_fld  i_fld,
    output t_days o_days
);

    // stage a: centuries of year and year-1
    t_fld             r_fld;
    logic [QW-1:0]    r_q_prev;
    logic [QW-1:0]    r_q_cur;
    logic [YearW-1:0] year_prev;
    logic [24:0]      prod_prev;
    logic [24:0]      prod_cur;
    logic [QW-1:0]    n_q_prev;
    logic [QW-1:0]    n_q_cur;

    always_comb begin
        year_prev = i_fld.year - 12'd1;
        prod_prev = {13'd0, year_prev} * {12'd0, Recip100};
        prod_cur  = {13'd0, i_fld.year} * {12'd0, Recip100};
        n_q_prev  = prod_prev[RecipShift +: QW];
        n_q_cur   = prod_cur[RecipShift +: QW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fld.valid <= 1'b0;
        end else begin
            r_fld.valid <= i_fld.valid;
        end
        r_fld.ok     <= i_fld.ok;
        r_fld.year   <= i_fld.year;
        r_fld.mon    <= i_fld.mon;
        r_fld.day    <= i_fld.day;
        r_fld.hour   <= i_fld.hour;
        r_fld.minute <= i_fld.minute;
        r_fld.sec    <= i_fld.sec;
        r_fld.zone   <= i_fld.zone;
        r_q_prev     <= n_q_prev;
        r_q_cur      <= n_q_cur;
    end

    // stage b: day count and time of day
    t_days            r_days;
    t_days            n_days;
    logic [YearW-1:0] yp;
    logic [YearW-1:0] leaps;
    logic             leap;
    logic [YearW-1:0] rem100;
    logic [4:0]       mlen;
    logic             day_ok;
    logic [20:0]      base_days;
    logic [20:0]      sum_days;
    logic [16:0]      hour_secs;
    logic [11:0]      min_secs;

    always_comb begin
        yp        = r_fld.year - 12'd1;
        leaps     = {2'b00, yp[YearW-1:2]} - {{(YearW-QW){1'b0}}, r_q_prev}
                    + {{(YearW-QW+2){1'b0}}, r_q_prev[QW-1:2]} - LeapsBase;
        rem100    = r_fld.year - 12'({r_q_cur, 7'd0} - {r_q_cur, 5'd0} + {r_q_cur, 2'd0});
        leap      = (r_fld.year[1:0] == 2'b00)
                    && ((rem100 != 12'd0) || (r_q_cur[1:0] == 2'b00));
        mlen      = month_len(r_fld.mon) + {4'd0, leap && (r_fld.mon == MonFeb)};
        day_ok    = (r_fld.day != 6'd0) && (r_fld.day <= {1'b0, mlen});
        base_days = 21'(r_fld.year - EpochYear) * {12'd0, DaysYear};
        sum_days  = base_days + {9'd0, leaps} + {12'd0, days_before(r_fld.mon)}
                    + {20'd0, leap && (r_fld.mon > MonFeb)}
                    + {15'd0, r_fld.day} - 21'd1;
        hour_secs = {11'd0, r_fld.hour} * {5'd0, SecsHour};
        min_secs  = {6'd0, r_fld.minute} * {6'd0, SecsMin};

        n_days.valid = r_fld.valid;
        n_days.ok    = r_fld.ok && day_ok;
        n_days.days  = sum_days[DaysW-1:0];
        n_days.tod   = hour_secs + {5'd0, min_secs} + {11'd0, r_fld.sec};
        n_days.zone  = r_fld.zone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_days.valid <= 1'b0;
        end else begin
            r_days.valid <= n_days.valid;
        end
        r_days.ok   <= n_days.ok;
        r_days.days <= n_days.days;
        r_days.tod  <= n_days.tod;
        r_days.zone <= n_days.zone;
    end

    assign o_days = r_days;

endmodule

// File: rtl/cte_epoch_calc.sv
module cte_epoch_calc
    import cte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_days             i_days,
    output logic              o_strobe,
    output logic              o_date_valid,
    output logic [EpochW-1:0] o_epoch_seconds,
    output logic [ZoneW-1:0]  o_zone_out
);

    // stage c: local seconds
    logic              r_valid_c;
    logic              r_ok_c;
    logic [EpochW-1:0] r_local;
    logic [ZoneW-1:0]  r_zone_c;
    logic [EpochW-1:0] n_local;

    assign n_local = 37'({17'd0, i_days.days} * {20'd0, SecsDay}) + {20'd0, i_days.tod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
        end else begin
            r_valid_c <= i_days.valid;
        end
        r_ok_c   <= i_days.ok;
        r_local  <= n_local;
        r_zone_c <= i_days.zone;
    end

    // stage d: zone adjust, zero for an invalid date, falls back to local time if it would go negative
    logic              r_strobe;
    logic              r_date_valid;
    logic [EpochW-1:0] r_epoch;
    logic [ZoneW-1:0]  r_zone;
    logic [EpochW+1:0] diff;
    logic [EpochW-1:0] n_epoch;

    always_comb begin
        diff = {2'b00, r_local} - {{(EpochW-ZoneW+2){r_zone_c[ZoneW-1]}}, r_zone_c};
        if (!r_ok_c) begin
            n_epoch = '0;
        end else if (diff[EpochW+1]) begin
            n_epoch = r_local;
        end else begin
            n_epoch = diff[EpochW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_valid_c;
        end
        r_date_valid <= r_ok_c;
        r_epoch      <= n_epoch;
        r_zone       <= r_zone_c;
    end

    assign o_strobe        = r_strobe;
    assign o_date_valid    = r_date_valid;
    assign o_epoch_seconds = r_epoch;
    assign o_zone_out      = r_zone;

endmodule

// File: rtl/calendar_to_epoch_seconds_core.sv
// calendar date and time to seconds since 1970-01-01 utc
//
// input transaction: drive the fields and raise start; it is taken at the
// rising edge where start is high and busy is low. busy is high during reset
// and until the register r_busy clears after it, and low from then on, so a
// new transaction can be taken every cycle.
// result transaction: o_strobe is high for one cycle with o_date_valid,
// o_epoch_seconds and o_zone_out; it is taken at the edge ending that cycle.
// every input transaction gives exactly one result, in order.
// pipeline: the fields pass from the accepting edge through the registered
// stages field check, century split, day count, seconds multiply and zone
// adjust. throughput: one transaction per cycle, set by the fully
// pipelined datapath.
// reset clears all valid bits; transactions in flight are dropped.
// the receiver cannot stall, so the pipeline never holds.
module calendar_to_epoch_seconds_core
    import cte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DayW-1:0]   i_day_of_month,
    input  logic [MonW-1:0]   i_month_index,
    input  logic [YearW-1:0]  i_year_value,
    input  logic [TimeW-1:0]  i_hour_value,
    input  logic [TimeW-1:0]  i_minute_value,
    input  logic [TimeW-1:0]  i_second_value,
    input  logic [ZoneW-1:0]  i_zone_offset,
    output logic              o_strobe,
    output logic              o_date_valid,
    output logic [EpochW-1:0] o_epoch_seconds,
    output logic [ZoneW-1:0]  o_zone_out
);

    logic  r_busy;
    logic  accept;
    t_fld  fld;
    t_days days;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    cte_field_check u_field_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_day    (i_day_of_month),
        .i_mon    (i_month_index),
        .i_year   (i_year_value),
        .i_hour   (i_hour_value),
        .i_minute (i_minute_value),
        .i_sec    (i_second_value),
        .i_zone   (i_zone_offset),
        .o_fld    (fld)
    );

    cte_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fld   (fld),
        .o_days  (days)
    );

    cte_epoch_calc u_epoch_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_days          (days),
        .o_strobe        (o_strobe),
        .o_date_valid    (o_date_valid),
        .o_epoch_seconds (o_epoch_seconds),
        .o_zone_out      (o_zone_out)
    );

endmodule
